@@ rtl/core/fowe_pkg.sv @@
// shared constants, types and helpers of the out-of-bag weight engine
package fowe_pkg;

  localparam int MAX_SAMPLES = 256;
  localparam int MAX_TREES   = 64;
  localparam int DEPTH       = MAX_SAMPLES * MAX_TREES;
  localparam int ADDR_W      = $clog2(DEPTH);

  localparam int SAMPLE_W = 8;
  localparam int TREE_W   = 6;
  localparam int LEAF_W   = 16;
  localparam int INBAG_W  = 8;
  localparam int ENTRY_W  = LEAF_W + INBAG_W;
  localparam int TRAIN_W  = 9;
  localparam int TREEC_W  = 7;
  localparam int WEIGHT_W = 17;
  localparam int WSHIFT   = 16;

  localparam int SIDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int TIDX_W = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
  localparam int SCNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int TCNT_W = $clog2(MAX_TREES + 1);

  localparam int INBAG_MAX = 255;
  localparam int LSUM_W    = $clog2(MAX_SAMPLES * INBAG_MAX + 1);
  localparam int FRAC_W    = 32;
  localparam int SHARE_W   = FRAC_W + 1;
  localparam int TOT_W     = SHARE_W + TCNT_W;
  localparam int DIVN_W    = (TOT_W > INBAG_W + FRAC_W) ? TOT_W : INBAG_W + FRAC_W;
  localparam int DIVD_W    = (LSUM_W > TCNT_W) ? LSUM_W : TCNT_W;
  localparam int DCNT_W    = $clog2(DIVN_W + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TRAIN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIN_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TREE_COUNT  = 1'b1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QCHK,
    ST_TGT_RD,
    ST_TGT_CHK,
    ST_SMP_RD,
    ST_SMP_CHK,
    ST_SCAN,
    ST_DRAIN,
    ST_SHARE_CHK,
    ST_SHARE_DIV,
    ST_NEXT_TREE,
    ST_FINAL,
    ST_FINAL_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    ADR_LOAD,
    ADR_TARGET,
    ADR_SAMPLE,
    ADR_SCAN
  } addr_sel_t;

  typedef struct packed {
    logic      load_we;
    logic      query_start;
    addr_sel_t addr_sel;
    logic      tgt_take;
    logic      smp_take;
    logic      scan_issue;
    logic      share_start;
    logic      share_take;
    logic      tree_next;
    logic      final_start;
    logic      final_take;
    logic      weight_clear;
  } cmd_t;

  typedef struct packed {
    logic target_ok;
    logic trees_none;
    logic tgt_oob;
    logic sample_ok;
    logic smp_match;
    logic scan_last;
    logic lsum_nz;
    logic tree_last;
    logic b_zero;
    logic div_done;
  } status_t;

  function automatic logic [ADDR_W-1:0] slot(input int unsigned s, input int unsigned t);
    return ADDR_W'(s * MAX_TREES + t);
  endfunction

endpackage

@@ rtl/core/fowe_if.sv @@
// channel interfaces of the out-of-bag weight engine
interface fowe_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [fowe_pkg::SAMPLE_W-1:0] sample_index;
  logic [fowe_pkg::TREE_W-1:0]   tree_index;
  logic [fowe_pkg::LEAF_W-1:0]   leaf_id;
  logic [fowe_pkg::INBAG_W-1:0]  inbag_count;
  logic [fowe_pkg::SAMPLE_W-1:0] target_index;
  modport source (output valid, kind, sample_index, tree_index, leaf_id, inbag_count,
                  target_index, input ready);
  modport sink (input valid, kind, sample_index, tree_index, leaf_id, inbag_count,
                target_index, output ready);
endinterface

interface fowe_out_if;
  logic                          valid;
  logic                          ready;
  logic [fowe_pkg::WEIGHT_W-1:0] weight;
  logic                          never_out_of_bag;
  modport source (output valid, weight, never_out_of_bag, input ready);
  modport sink (input valid, weight, never_out_of_bag, output ready);
endinterface

@@ rtl/core/fowe_ram.sv @@
// generic single-port ram with registered read
module fowe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/core/fowe_div.sv @@
// restoring divider, one quotient bit per cycle
module fowe_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fowe_pkg::DIVN_W-1:0]   dividend,
  input  logic [fowe_pkg::DIVD_W-1:0]   divisor,
  output logic                          done,
  output logic [fowe_pkg::DIVN_W-1:0]   quotient
);
  logic [fowe_pkg::DIVD_W-1:0] rem_r, rem_nxt;
  logic [fowe_pkg::DIVD_W-1:0] dvs_r;
  logic [fowe_pkg::DIVN_W-1:0] quo_r, quo_nxt;
  logic [fowe_pkg::DCNT_W-1:0] cnt_r;
  logic                        run_r;
  logic                        done_r;
  logic [fowe_pkg::DIVD_W:0]   trial;
  logic [fowe_pkg::DIVD_W:0]   diff;

  always_comb begin
    trial   = {rem_r, quo_r[fowe_pkg::DIVN_W-1]};
    diff    = trial - {1'b0, dvs_r};
    quo_nxt = {quo_r[fowe_pkg::DIVN_W-2:0], 1'b0};
    rem_nxt = trial[fowe_pkg::DIVD_W-1:0];
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt    = diff[fowe_pkg::DIVD_W-1:0];
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == fowe_pkg::DCNT_W'(1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= fowe_pkg::DCNT_W'(fowe_pkg::DIVN_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - fowe_pkg::DCNT_W'(1);
        if (cnt_r == fowe_pkg::DCNT_W'(1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

@@ rtl/core/fowe_datapath.sv @@
// table memory, counters, leaf sum and weight accumulation
module fowe_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fowe_pkg::cmd_t                 cmd,
  input  logic [fowe_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [fowe_pkg::TREE_W-1:0]    in_tree,
  input  logic [fowe_pkg::LEAF_W-1:0]    in_leaf,
  input  logic [fowe_pkg::INBAG_W-1:0]   in_inbag,
  input  logic [fowe_pkg::SAMPLE_W-1:0]  in_target,
  input  logic [fowe_pkg::TRAIN_W-1:0]   train_count,
  input  logic [fowe_pkg::TREEC_W-1:0]   tree_count,
  output fowe_pkg::status_t              status,
  output logic [fowe_pkg::WEIGHT_W-1:0]  weight,
  output logic                           never_oob
);
  logic [fowe_pkg::SCNT_W-1:0]   ns;
  logic [fowe_pkg::TCNT_W-1:0]   nt;
  logic [fowe_pkg::SAMPLE_W-1:0] sample_r;
  logic [fowe_pkg::SAMPLE_W-1:0] target_r;
  logic [fowe_pkg::TIDX_W-1:0]   k_r;
  logic [fowe_pkg::SIDX_W-1:0]   i_r;
  logic [fowe_pkg::TCNT_W-1:0]   b_r;
  logic [fowe_pkg::LEAF_W-1:0]   tleaf_r;
  logic [fowe_pkg::INBAG_W-1:0]  cnt_r;
  logic [fowe_pkg::LSUM_W-1:0]   lsum_r;
  logic [fowe_pkg::TOT_W-1:0]    total_r;
  logic                          acc_en_r;
  logic [fowe_pkg::WEIGHT_W-1:0] weight_r;
  logic                          load_ok;
  logic                          mem_we;
  logic [fowe_pkg::ADDR_W-1:0]   addr;
  logic [fowe_pkg::ENTRY_W-1:0]  rdata;
  logic [fowe_pkg::LEAF_W-1:0]   rd_leaf;
  logic [fowe_pkg::INBAG_W-1:0]  rd_inbag;
  logic                          div_start;
  logic [fowe_pkg::DIVN_W-1:0]   div_n;
  logic [fowe_pkg::DIVD_W-1:0]   div_d;
  logic                          div_done;
  logic [fowe_pkg::DIVN_W-1:0]   div_q;

  assign ns = (32'(train_count) > fowe_pkg::MAX_SAMPLES) ?
              fowe_pkg::SCNT_W'(fowe_pkg::MAX_SAMPLES) : fowe_pkg::SCNT_W'(train_count);
  assign nt = (32'(tree_count) > fowe_pkg::MAX_TREES) ?
              fowe_pkg::TCNT_W'(fowe_pkg::MAX_TREES) : fowe_pkg::TCNT_W'(tree_count);

  assign load_ok = (32'(in_sample) < fowe_pkg::MAX_SAMPLES) &&
                   (32'(in_tree) < fowe_pkg::MAX_TREES);
  assign mem_we  = cmd.load_we && load_ok;

  always_comb begin
    case (cmd.addr_sel)
      fowe_pkg::ADR_LOAD:   addr = fowe_pkg::slot(32'(in_sample), 32'(in_tree));
      fowe_pkg::ADR_TARGET: addr = fowe_pkg::slot(32'(target_r), 32'(k_r));
      fowe_pkg::ADR_SAMPLE: addr = fowe_pkg::slot(32'(sample_r), 32'(k_r));
      fowe_pkg::ADR_SCAN:   addr = fowe_pkg::slot(32'(i_r), 32'(k_r));
      default:              addr = '0;
    endcase
  end

  fowe_ram #(
    .WIDTH (fowe_pkg::ENTRY_W),
    .DEPTH (fowe_pkg::DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .addr  (addr),
    .wdata ({in_leaf, in_inbag}),
    .rdata (rdata)
  );

  assign rd_leaf  = rdata[fowe_pkg::ENTRY_W-1:fowe_pkg::INBAG_W];
  assign rd_inbag = rdata[fowe_pkg::INBAG_W-1:0];

  // shared divider: per-tree share, then the final average
  assign div_start = cmd.share_start || cmd.final_start;
  assign div_n = cmd.final_start ? fowe_pkg::DIVN_W'(total_r) :
                 fowe_pkg::DIVN_W'({cnt_r, fowe_pkg::FRAC_W'(0)});
  assign div_d = cmd.final_start ? fowe_pkg::DIVD_W'(b_r) : fowe_pkg::DIVD_W'(lsum_r);

  fowe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      sample_r <= in_sample;
      target_r <= in_target;
      k_r      <= '0;
      b_r      <= '0;
      total_r  <= '0;
    end
    if (cmd.tgt_take) begin
      b_r     <= b_r + fowe_pkg::TCNT_W'(1);
      tleaf_r <= rd_leaf;
    end
    if (cmd.smp_take) begin
      cnt_r  <= rd_inbag;
      i_r    <= '0;
      lsum_r <= '0;
    end
    if (cmd.scan_issue) begin
      i_r <= i_r + fowe_pkg::SIDX_W'(1);
    end
    if (acc_en_r && (rd_leaf == tleaf_r)) begin
      lsum_r <= lsum_r + fowe_pkg::LSUM_W'(rd_inbag);
    end
    if (cmd.share_take) begin
      total_r <= total_r + fowe_pkg::TOT_W'(div_q[fowe_pkg::SHARE_W-1:0]);
    end
    if (cmd.tree_next) begin
      k_r <= k_r + fowe_pkg::TIDX_W'(1);
    end
    if (cmd.final_take) begin
      weight_r <= div_q[fowe_pkg::WSHIFT +: fowe_pkg::WEIGHT_W];
    end
    if (cmd.weight_clear) begin
      weight_r <= '0;
    end
  end

  always_comb begin
    status.target_ok  = 32'(target_r) < 32'(ns);
    status.trees_none = (nt == '0);
    status.tgt_oob    = (rd_inbag == '0);
    status.sample_ok  = 32'(sample_r) < 32'(ns);
    status.smp_match  = (rd_leaf == tleaf_r);
    status.scan_last  = (32'(i_r) + 32'd1) == 32'(ns);
    status.lsum_nz    = (lsum_r != '0);
    status.tree_last  = (32'(k_r) + 32'd1) == 32'(nt);
    status.b_zero     = (b_r == '0);
    status.div_done   = div_done;
  end

  assign weight    = weight_r;
  assign never_oob = (b_r == '0);
endmodule

@@ rtl/core/fowe_ctrl.sv @@
// sequencer of loads and queries
module fowe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  input  logic              out_free,
  input  fowe_pkg::status_t status,
  output logic              in_ready,
  output logic              res_we,
  output fowe_pkg::cmd_t    cmd
);
  fowe_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fowe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    res_we    = 1'b0;
    case (state_r)
      fowe_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.addr_sel = fowe_pkg::ADR_LOAD;
        if (in_valid && in_kind == fowe_pkg::KIND_LOAD) begin
          cmd.load_we = 1'b1;
        end else if (in_valid) begin
          cmd.query_start = 1'b1;
          state_nxt       = fowe_pkg::ST_QCHK;
        end
      end
      fowe_pkg::ST_QCHK: begin
        if (status.target_ok && !status.trees_none) begin
          state_nxt = fowe_pkg::ST_TGT_RD;
        end else begin
          state_nxt = fowe_pkg::ST_FINAL;
        end
      end
      fowe_pkg::ST_TGT_RD: begin
        cmd.addr_sel = fowe_pkg::ADR_TARGET;
        state_nxt    = fowe_pkg::ST_TGT_CHK;
      end
      fowe_pkg::ST_TGT_CHK: begin
        if (!status.tgt_oob) begin
          state_nxt = fowe_pkg::ST_NEXT_TREE;
        end else begin
          cmd.tgt_take = 1'b1;
          state_nxt    = status.sample_ok ? fowe_pkg::ST_SMP_RD : fowe_pkg::ST_NEXT_TREE;
        end
      end
      fowe_pkg::ST_SMP_RD: begin
        cmd.addr_sel = fowe_pkg::ADR_SAMPLE;
        state_nxt    = fowe_pkg::ST_SMP_CHK;
      end
      fowe_pkg::ST_SMP_CHK: begin
        cmd.smp_take = 1'b1;
        state_nxt    = status.smp_match ? fowe_pkg::ST_SCAN : fowe_pkg::ST_NEXT_TREE;
      end
      fowe_pkg::ST_SCAN: begin
        cmd.addr_sel   = fowe_pkg::ADR_SCAN;
        cmd.scan_issue = 1'b1;
        if (status.scan_last) begin
          state_nxt = fowe_pkg::ST_DRAIN;
        end
      end
      fowe_pkg::ST_DRAIN: begin
        state_nxt = fowe_pkg::ST_SHARE_CHK;
      end
      fowe_pkg::ST_SHARE_CHK: begin
        if (status.lsum_nz) begin
          cmd.share_start = 1'b1;
          state_nxt       = fowe_pkg::ST_SHARE_DIV;
        end else begin
          state_nxt = fowe_pkg::ST_NEXT_TREE;
        end
      end
      fowe_pkg::ST_SHARE_DIV: begin
        if (status.div_done) begin
          cmd.share_take = 1'b1;
          state_nxt      = fowe_pkg::ST_NEXT_TREE;
        end
      end
      fowe_pkg::ST_NEXT_TREE: begin
        if (status.tree_last) begin
          state_nxt = fowe_pkg::ST_FINAL;
        end else begin
          cmd.tree_next = 1'b1;
          state_nxt     = fowe_pkg::ST_TGT_RD;
        end
      end
      fowe_pkg::ST_FINAL: begin
        if (status.b_zero) begin
          cmd.weight_clear = 1'b1;
          state_nxt        = fowe_pkg::ST_DONE;
        end else begin
          cmd.final_start = 1'b1;
          state_nxt       = fowe_pkg::ST_FINAL_DIV;
        end
      end
      fowe_pkg::ST_FINAL_DIV: begin
        if (status.div_done) begin
          cmd.final_take = 1'b1;
          state_nxt      = fowe_pkg::ST_DONE;
        end
      end
      fowe_pkg::ST_DONE: begin
        if (out_free) begin
          res_we    = 1'b1;
          state_nxt = fowe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fowe_pkg::ST_IDLE;
      end
    endcase
  end
endmodule

@@ rtl/core/forest_oob_weight_engine.sv @@
// top level of the out-of-bag weight engine
//
//   port     dir   handshake     carries
//   in_tr    in    valid/ready   load of one table entry, or one weight query
//   out_tr   out   valid/ready   weight and never_out_of_bag, one per query
//   cfg_*    in    cfg_we        train_count (index 0), tree_count (index 1)
//
// a load is written to the table from idle; the length of a query is set by the
// trees in use, the sequential scan over samples on the single table port and the
// one-bit-per-cycle divider
// the result register frees the input side once a result is waiting
// synchronous active-low reset; table contents are not cleared
module forest_oob_weight_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  fowe_in_if.sink                           in_tr,
  fowe_out_if.source                        out_tr,
  input  logic                              cfg_we,
  input  logic [fowe_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [fowe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  logic [fowe_pkg::TRAIN_W-1:0]  train_count_r;
  logic [fowe_pkg::TREEC_W-1:0]  tree_count_r;
  logic                          out_valid_r;
  logic [fowe_pkg::WEIGHT_W-1:0] out_weight_r;
  logic                          out_nob_r;
  logic                          out_free;
  logic                          res_we;
  fowe_pkg::cmd_t                cmd;
  fowe_pkg::status_t             status;
  logic [fowe_pkg::WEIGHT_W-1:0] weight;
  logic                          never_oob;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      train_count_r <= fowe_pkg::TRAIN_W'(256);
      tree_count_r  <= fowe_pkg::TREEC_W'(64);
    end else if (cfg_we) begin
      case (cfg_idx)
        fowe_pkg::CFG_TRAIN_COUNT: train_count_r <= cfg_wdata[fowe_pkg::TRAIN_W-1:0];
        fowe_pkg::CFG_TREE_COUNT:  tree_count_r  <= cfg_wdata[fowe_pkg::TREEC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid_r || out_tr.ready;

  fowe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tr.valid),
    .in_kind  (in_tr.kind),
    .out_free (out_free),
    .status   (status),
    .in_ready (in_tr.ready),
    .res_we   (res_we),
    .cmd      (cmd)
  );

  fowe_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_sample   (in_tr.sample_index),
    .in_tree     (in_tr.tree_index),
    .in_leaf     (in_tr.leaf_id),
    .in_inbag    (in_tr.inbag_count),
    .in_target   (in_tr.target_index),
    .train_count (train_count_r),
    .tree_count  (tree_count_r),
    .status      (status),
    .weight      (weight),
    .never_oob   (never_oob)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_we) begin
      out_valid_r <= 1'b1;
    end else if (out_tr.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      out_weight_r <= weight;
      out_nob_r    <= never_oob;
    end
  end

  assign out_tr.valid            = out_valid_r;
  assign out_tr.weight           = out_weight_r;
  assign out_tr.never_out_of_bag = out_nob_r;

  a_res_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_we |-> (!out_valid_r || out_tr.ready))
    else $error("result written over a pending transaction");

  a_res_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res_we |=> out_valid_r)
    else $error("result not presented after write");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tr.valid && in_tr.ready && in_tr.kind == fowe_pkg::KIND_LOAD) |=> !res_we)
    else $error("load produced a result");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tr.valid && in_tr.ready && in_tr.kind == fowe_pkg::KIND_QUERY) |=> !in_tr.ready)
    else $error("input taken while a query is in progress");
endmodule
